@@ design/spa_pkg.sv @@
// Shared types and constants of the slot pool allocator.
// Used by slot_pool_allocator_evict_oldest_core; no dependencies.
package spa_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int MASK_W = 6;

  localparam logic [6:0]  SLOT_NONE    = 7'd127;
  localparam logic [15:0] WINDOW_RESET = 16'd750;
  localparam logic [31:0] DIST_RESET   = 32'd655;

  localparam logic [7:0] REG_DEDUPE_WINDOW = 8'd0;
  localparam logic [7:0] REG_DEDUPE_DIST   = 8'd1;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_EVICTED = 2'd1,
    ST_DUP     = 2'd2,
    ST_SWEPT   = 2'd3
  } status_t;

  typedef struct packed {
    logic               action;
    logic [15:0]        elapsed_ms;
    logic [9:0]         area_id;
    logic [31:0]        asset_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [63:0]        finished_mask;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] slot;
    logic [5:0] evicted_slot;
    logic [6:0] removed_count;
    logic [6:0] active_count;
  } out_t;

endpackage

@@ design/slot_pool_allocator_evict_oldest_core.sv @@
// Slot pool allocator with oldest-first eviction: top level.
// Depends on spa_pkg and spa_ram.

// An add goes from transfer to result through the difference squares, the
// dedupe compare, one read of the slot memory or of the live-order memory,
// and the result register; a suppressed duplicate skips the read. An update
// sweeps the live list: the sweep reads the live-order memory one entry per
// cycle through a three-stage pipeline (order read, area read, keep-or-free),
// so that read port sets the pace. One item is worked on at a time; the next
// is taken once the current result sits in the output register. The state
// sits in two memories: the live-order memory and a slot memory that holds
// each slot's free-list link and area tag. The slot memory needs no clearing
// pass after reset: a flip-flop per slot marks links written since reset, and
// an unwritten link reads as its reset value (slot i points to i-1). The live
// order is kept as a ring (base pointer plus count), so an eviction only
// moves the base. Configuration writes are always taken.
module slot_pool_allocator_evict_oldest_core #(
  parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spa_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_MUL, S_ADD_CHK, S_ADD_POP, S_SWEEP, S_RESP
  } state_t;

  state_t state;

  spa_pkg::in_t  item;
  spa_pkg::out_t res;

  logic [15:0] window;
  logic [31:0] dist_thr;

  logic [6:0]       free_head;
  logic [SLOTS-1:0] link_written;
  logic [IW-1:0]    live_base;
  logic [CW-1:0]    live_count;
  logic [15:0]      time_since_add;
  logic [6:0]       last_slot;
  logic [31:0]      last_asset;
  logic signed [23:0] last_x, last_y, last_z;

  logic [47:0] sq_x, sq_y, sq_z;

  logic [CW-1:0] rd_i, kept, removed;
  logic          a_v, b_v;
  logic [IW-1:0] b_s;

  // memory ports
  logic          fn_we;
  logic [IW-1:0] fn_waddr;
  logic [6:0]    fn_wdata, fn_rdata;
  logic          lo_we;
  logic [IW-1:0] lo_waddr, lo_raddr, lo_rdata, lo_wdata;
  logic          ar_we;
  logic [9:0]    ar_rdata;
  logic          sm_we;
  logic [IW-1:0] sm_waddr, sm_raddr;
  logic [16:0]   sm_wdata, sm_rdata;

  function automatic logic [IW-1:0] wrap(input logic [CW:0] v);
    if (v >= (CW+1)'(SLOTS)) begin
      return IW'(v - (CW+1)'(SLOTS));
    end
    return IW'(v);
  endfunction

  // Slot memory: free-list link in the upper bits, area tag in the lower bits.
  // A link matters only while its slot is free and a tag only while its slot
  // is live, so a write to one half may overwrite the other.
  spa_ram #(.WIDTH(17), .DEPTH(SLOTS)) u_slot_mem (
    .clk, .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata)
  );

  spa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_live_order (
    .clk, .we(lo_we), .waddr(lo_waddr), .wdata(lo_wdata),
    .raddr(lo_raddr), .rdata(lo_rdata)
  );

  // Read the area tag during a sweep, else the link at the free head.
  assign sm_we    = fn_we || ar_we;
  assign sm_waddr = fn_we ? fn_waddr : lo_wdata;
  assign sm_wdata = {fn_wdata, item.area_id};
  assign sm_raddr = (state == S_SWEEP) ? lo_rdata : free_head[IW-1:0];
  assign fn_rdata = sm_rdata[16:10];
  assign ar_rdata = sm_rdata[9:0];

  // Dedupe arithmetic: 25-bit differences squared, then summed next cycle.
  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] px, py, pz;
  logic [49:0]        d2;
  logic               dup_cand, dup;

  assign dx = 25'(item.pos_x) - 25'(last_x);
  assign dy = 25'(item.pos_y) - 25'(last_y);
  assign dz = 25'(item.pos_z) - 25'(last_z);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;
  assign d2 = 50'(sq_x) + 50'(sq_y) + 50'(sq_z);

  assign dup_cand = (last_slot < 7'(SLOTS)) && (time_since_add < window) &&
                    (last_asset == item.asset_id);
  assign dup = dup_cand && (d2 < 50'(dist_thr));

  // Add-path decode.
  logic          head_ok, add_fail;
  logic [IW-1:0] add_s;
  logic [6:0]    head_next;

  assign head_ok  = free_head < 7'(SLOTS);
  assign add_fail = head_ok && (live_count >= CW'(SLOTS));
  assign add_s    = head_ok ? free_head[IW-1:0] : lo_rdata;
  always_comb begin
    if (link_written[free_head[IW-1:0]]) begin
      head_next = fn_rdata;
    end else if (free_head == 7'd0) begin
      head_next = spa_pkg::SLOT_NONE;
    end else begin
      head_next = free_head - 7'd1;
    end
  end

  // Sweep keep-or-free decision at the last pipeline stage.
  logic drop;
  assign drop = (ar_rdata != item.area_id) ||
                item.finished_mask[spa_pkg::MASK_W'(b_s)];

  logic [16:0] time_sum;
  assign time_sum = 17'(time_since_add) + 17'(in_data.elapsed_ms);

  // Memory port steering.
  always_comb begin
    fn_we    = 1'b0;
    fn_waddr = b_s;
    fn_wdata = free_head;
    lo_we    = 1'b0;
    lo_waddr = wrap((CW+1)'(live_base) + (CW+1)'(live_count));
    lo_wdata = add_s;
    lo_raddr = live_base;
    ar_we    = 1'b0;
    unique case (state)
      S_ADD_POP: begin
        lo_we = !add_fail;
        ar_we = !add_fail;
      end
      S_SWEEP: begin
        lo_raddr = wrap((CW+1)'(live_base) + (CW+1)'(rd_i));
        lo_waddr = wrap((CW+1)'(live_base) + (CW+1)'(kept));
        lo_wdata = b_s;
        lo_we    = b_v && !drop;
        fn_we    = b_v && drop;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window         <= spa_pkg::WINDOW_RESET;
      dist_thr       <= spa_pkg::DIST_RESET;
      free_head      <= 7'(SLOTS - 1);
      link_written   <= '0;
      live_base      <= '0;
      live_count     <= '0;
      time_since_add <= '0;
      last_slot      <= spa_pkg::SLOT_NONE;
      last_asset     <= '1;
      last_x         <= '0;
      last_y         <= '0;
      last_z         <= '0;
      out_valid      <= 1'b0;
      a_v            <= 1'b0;
      b_v            <= 1'b0;
      rd_i           <= '0;
      kept           <= '0;
      removed        <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == spa_pkg::REG_DEDUPE_WINDOW) begin
          window <= cfg_data[15:0];
        end else if (cfg_index == spa_pkg::REG_DEDUPE_DIST) begin
          dist_thr <= cfg_data;
        end
      end

      // drop the taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            if (in_data.action == spa_pkg::ACT_UPDATE) begin
              // saturate the timer, then start the sweep
              time_since_add <= time_sum[16] ? 16'hFFFF : time_sum[15:0];
              rd_i    <= '0;
              kept    <= '0;
              removed <= '0;
              a_v     <= 1'b0;
              b_v     <= 1'b0;
              state   <= S_SWEEP;
            end else begin
              state <= S_ADD_MUL;
            end
          end
        end
        S_ADD_MUL: begin
          sq_x  <= px[47:0];
          sq_y  <= py[47:0];
          sq_z  <= pz[47:0];
          state <= S_ADD_CHK;
        end
        S_ADD_CHK: begin
          res.removed_count <= '0;
          res.active_count  <= 7'(live_count);
          res.evicted_slot  <= '0;
          if (dup) begin
            res.status <= spa_pkg::ST_DUP;
            res.slot   <= 6'(last_slot);
            state      <= S_RESP;
          end else if (head_ok || live_count != '0) begin
            state <= S_ADD_POP;
          end else begin
            // no free and no live slot: drop the add
            res.status <= spa_pkg::ST_DUP;
            res.slot   <= '0;
            state      <= S_RESP;
          end
        end
        S_ADD_POP: begin
          if (add_fail) begin
            res.status <= spa_pkg::ST_DUP;
            res.slot   <= '0;
          end else begin
            if (head_ok) begin
              // pop the free list
              free_head         <= head_next;
              live_count        <= live_count + CW'(1);
              res.status        <= spa_pkg::ST_ADDED;
              res.active_count  <= 7'(live_count + CW'(1));
            end else begin
              // evict the oldest and reuse it; the free list stays empty
              live_base        <= wrap((CW+1)'(live_base) + (CW+1)'(1));
              res.status       <= spa_pkg::ST_EVICTED;
              res.evicted_slot <= 6'(add_s);
            end
            res.slot       <= 6'(add_s);
            time_since_add <= '0;
            last_slot      <= 7'(add_s);
            last_asset     <= item.asset_id;
            last_x         <= item.pos_x;
            last_y         <= item.pos_y;
            last_z         <= item.pos_z;
          end
          state <= S_RESP;
        end
        S_SWEEP: begin
          // stage A: issue order read
          a_v <= (rd_i < live_count);
          if (rd_i < live_count) begin
            rd_i <= rd_i + CW'(1);
          end
          // stage B: order data arrives, area read issued
          b_v <= a_v;
          b_s <= lo_rdata;
          // stage C: keep (compact in place) or free
          if (b_v) begin
            if (drop) begin
              free_head              <= 7'(b_s);
              link_written[b_s]      <= 1'b1;
              removed                <= removed + CW'(1);
              if (last_slot == 7'(b_s)) begin
                last_slot <= spa_pkg::SLOT_NONE;
              end
            end else begin
              kept <= kept + CW'(1);
            end
          end
          if (rd_i == live_count && !a_v && !b_v) begin
            live_count        <= kept;
            res.status        <= spa_pkg::ST_SWEPT;
            res.slot          <= '0;
            res.evicted_slot  <= '0;
            res.removed_count <= 7'(removed);
            res.active_count  <= 7'(kept);
            state             <= S_RESP;
          end
        end
        S_RESP: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Live count never exceeds the pool.
  assert property (@(posedge clk) disable iff (rst) live_count <= CW'(SLOTS))
    else $error("live count above pool size");

  // Free head is either a real slot or the end marker.
  assert property (@(posedge clk) disable iff (rst)
    free_head < 7'(SLOTS) || free_head == spa_pkg::SLOT_NONE)
    else $error("free head out of range");

  // The sweep pipeline is drained whenever a new item can be taken.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !a_v && !b_v)
    else $error("sweep pipeline busy while idle");

  // Sweep compaction never writes the entry being read.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && lo_we && rd_i < live_count) |-> lo_waddr != lo_raddr)
    else $error("live order write hits pending read");

endmodule

@@ design/spa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/tb_slot_pool_allocator_evict_oldest_core.sv @@
// Testbench for slot_pool_allocator_evict_oldest_core: a free-list/live-list
// predictor checks every result; depends on spa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_slot_pool_allocator_evict_oldest_core;

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  spa_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  spa_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [7:0]    cfg_index;
  logic [31:0]   cfg_data;

  slot_pool_allocator_evict_oldest_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted pool state: LIFO free list, oldest-first live list, dedupe memory.
  logic [15:0]        window_ms;
  logic [31:0]        dist_sq;
  logic [6:0]         free_link [spa_pkg::SLOTS_DEFAULT];
  logic [6:0]         free_top;
  logic [5:0]         live_q [$];
  logic [9:0]         area_tag [spa_pkg::SLOTS_DEFAULT];
  int                 ms_since_add;
  logic [6:0]         last_added;
  logic [31:0]        last_asset_id;
  logic signed [23:0] last_pos [3];

  spa_pkg::out_t result_q [$];
  bit   failed = 1'b0;
  int   burst_left = 0;
  int   ready_mode = 0;

  // Track the previous add sent, so duplicate attempts can stay near it.
  logic [31:0]        prev_asset = '0;
  logic signed [23:0] prev_pos [3] = '{0, 0, 0};

  function automatic void pool_reset();
    window_ms = spa_pkg::WINDOW_RESET;
    dist_sq   = spa_pkg::DIST_RESET;
    for (int i = 0; i < spa_pkg::SLOTS_DEFAULT; i++) begin
      free_link[i] = (i == 0) ? spa_pkg::SLOT_NONE : 7'(i - 1);
      area_tag[i]  = '0;
    end
    free_top      = 7'(spa_pkg::SLOTS_DEFAULT - 1);
    live_q.delete();
    ms_since_add  = 0;
    last_added    = spa_pkg::SLOT_NONE;
    last_asset_id = '1;
    last_pos      = '{0, 0, 0};
  endfunction

  // Push a slot back on the free list; forget it as the last add.
  function automatic void release_slot(logic [5:0] s);
    free_link[s] = free_top;
    free_top     = {1'b0, s};
    if (last_added == {1'b0, s}) last_added = spa_pkg::SLOT_NONE;
  endfunction

  function automatic spa_pkg::out_t predict_pool(spa_pkg::in_t it);
    spa_pkg::out_t      r;
    logic [5:0]         keep_q [$];
    logic [5:0]         s;
    int                 removed;
    longint             d;
    longint unsigned    d2;
    logic signed [23:0] p [3];
    bit                 dup;
    r = '0;
    removed = 0;
    if (it.action == spa_pkg::ACT_UPDATE) begin
      ms_since_add += it.elapsed_ms;
      if (ms_since_add > 65535) ms_since_add = 65535;
      foreach (live_q[i]) begin
        s = live_q[i];
        if (area_tag[s] != it.area_id || it.finished_mask[s]) begin
          release_slot(s);
          removed++;
        end else begin
          keep_q = {keep_q, s};
        end
      end
      live_q = keep_q;
      r.status = spa_pkg::ST_SWEPT;
      r.removed_count = 7'(removed);
    end else begin
      p = '{it.pos_x, it.pos_y, it.pos_z};
      dup = 1'b0;
      if (last_added != spa_pkg::SLOT_NONE && ms_since_add < window_ms &&
          last_asset_id == it.asset_id) begin
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          d = longint'(p[k]) - longint'(last_pos[k]);
          d2 += longint'(d * d);
        end
        dup = d2 < {32'd0, dist_sq};
      end
      if (dup) begin
        r.status = spa_pkg::ST_DUP;
        r.slot   = last_added[5:0];
      end else begin
        r.status = spa_pkg::ST_ADDED;
        // Full pool: evict the oldest, then reuse it at once.
        if (free_top == spa_pkg::SLOT_NONE) begin
          s = live_q.pop_front();
          release_slot(s);
          r.status = spa_pkg::ST_EVICTED;
          r.evicted_slot = s;
        end
        s = free_top[5:0];
        free_top      = free_link[s];
        area_tag[s]   = it.area_id;
        ms_since_add  = 0;
        last_added    = {1'b0, s};
        last_asset_id = it.asset_id;
        last_pos      = p;
        live_q        = {live_q, s};
        r.slot = s;
      end
    end
    r.active_count = 7'(live_q.size());
    return r;
  endfunction

  // Send one item: open a new burst after a random gap, hold valid until transfer.
  task automatic send_item(spa_pkg::in_t it);
    int  gap;
    bit  took;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    result_q = {result_q, predict_pool(it)};
    burst_left--;
    if (it.action == spa_pkg::ACT_ADD) begin
      prev_asset = it.asset_id;
      prev_pos   = '{it.pos_x, it.pos_y, it.pos_z};
    end
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    if (idx == spa_pkg::REG_DEDUPE_WINDOW) window_ms = val[15:0];
    else if (idx == spa_pkg::REG_DEDUPE_DIST) dist_sq = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic spa_pkg::in_t make_add(logic [9:0] area, logic [31:0] asset,
                                            int x, int y, int z);
    spa_pkg::in_t it;
    it = '0;
    it.action   = spa_pkg::ACT_ADD;
    it.area_id  = area;
    it.asset_id = asset;
    it.pos_x = 24'(x);
    it.pos_y = 24'(y);
    it.pos_z = 24'(z);
    return it;
  endfunction

  function automatic spa_pkg::in_t make_update(logic [15:0] ms, logic [9:0] area,
                                               logic [63:0] mask);
    spa_pkg::in_t it;
    it = '0;
    it.action        = spa_pkg::ACT_UPDATE;
    it.elapsed_ms    = ms;
    it.area_id       = area;
    it.finished_mask = mask;
    return it;
  endfunction

  // Extremes of the fields, timer window edges, saturation, freed last add.
  task automatic test_directed();
    send_item(make_add(10'd0, 32'd0, 0, 0, 0));
    send_item(make_add(10'd0, 32'd0, 1, 1, 1));            // near, same asset: dup
    send_item(make_add(10'd0, 32'd0, 8388607, 8388607, 8388607));
    send_item(make_add(10'd1023, 32'hFFFF_FFFF, -8388608, -8388608, -8388608));
    send_item(make_update(16'hFFFF, 10'd0, 64'd0));        // frees last add
    send_item(make_update(16'hFFFF, 10'd0, 64'd0));        // timer saturates
    send_item(make_add(10'd0, 32'd0, 0, 0, 0));            // no dedupe memory
    send_item(make_add(10'd0, 32'd0, 0, 0, 0));            // dup at time zero
    send_item(make_update(16'd749, 10'd0, 64'd0));
    send_item(make_add(10'd0, 32'd0, 0, 0, 0));            // still inside window
    send_item(make_update(16'd1, 10'd0, 64'd0));
    send_item(make_add(10'd0, 32'd0, 0, 0, 0));            // window expired
    send_item(make_update(16'd0, 10'd0, '1));              // all finished
    send_item(make_add(10'd1023, 32'd5, 10, 0, 0));
    send_item(make_add(10'd1023, 32'd5, 35, 0, 0));        // just inside distance
    send_item(make_add(10'd1023, 32'd5, 36, 0, 0));        // just outside
    send_item(make_add(10'd1023, 32'd6, 36, 0, 0));        // other asset
    send_item(make_update(16'd3, 10'd1023, 64'h8000_0000_0000_0001));
    send_item(make_update(16'd0, 10'd1023, 64'hAAAA_5555_F0F0_0F0F));
    send_item(make_update(16'd0, 10'd512, 64'd0));         // area change frees all
    drain();
  endtask

  // Fill past capacity so every further add evicts the oldest slot.
  task automatic test_pool_full();
    for (int i = 0; i < 72; i++)
      send_item(make_add(10'(i % 3), 32'(i + 100), i * 1000, -i, i));
    send_item(make_update(16'd20, 10'd1, 64'd0));
    send_item(make_update(16'd20, 10'd7, 64'd0));
    drain();
  endtask

  // Mostly well-formed traffic: duplicate attempts near the last add, sweeps
  // that keep most entries, plus some full-range noise.
  task automatic test_random(int n_items);
    spa_pkg::in_t it;
    logic [9:0]   cur_area;
    int           pick;
    cur_area = 10'($urandom_range(0, 1023));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 40) == 0) cur_area = 10'($urandom());
      if (pick < 18) begin
        it = make_update($urandom_range(0, 3) == 0 ? 16'($urandom()) :
                         16'($urandom_range(0, 300)), cur_area,
                         $urandom_range(0, 3) == 0 ? {$urandom(), $urandom()} :
                         {$urandom(), $urandom()} & {$urandom(), $urandom()} &
                         {$urandom(), $urandom()} & {$urandom(), $urandom()});
        if ($urandom_range(0, 9) == 0) it.area_id = 10'($urandom());
      end else if (pick < 55) begin
        it = make_add(cur_area, prev_asset,
                      int'(prev_pos[0]) + int'($urandom_range(0, 40)) - 20,
                      int'(prev_pos[1]) + int'($urandom_range(0, 40)) - 20,
                      int'(prev_pos[2]) + int'($urandom_range(0, 40)) - 20);
      end else if (pick < 85) begin
        it = make_add(cur_area, 32'($urandom_range(0, 7)),
                      $urandom_range(0, 4000), $urandom_range(0, 4000),
                      $urandom_range(0, 4000));
      end else begin
        it = make_add(10'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
      end
      send_item(it);
    end
    drain();
  endtask

  task automatic test_config_phases();
    test_random(140);
    write_reg(spa_pkg::REG_DEDUPE_WINDOW, 32'd0);
    write_reg(spa_pkg::REG_DEDUPE_DIST, 32'd0);
    test_random(110);
    write_reg(spa_pkg::REG_DEDUPE_WINDOW, 32'd65535);
    write_reg(spa_pkg::REG_DEDUPE_DIST, 32'hFFFF_FFFF);
    test_random(110);
    write_reg(spa_pkg::REG_DEDUPE_WINDOW, 32'($urandom_range(100, 2000)));
    write_reg(spa_pkg::REG_DEDUPE_DIST, 32'($urandom_range(100, 3000)));
    test_random(140);
  endtask

  // Receiver stall pattern: change mode now and then; mode 0 never stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 150) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each transfer field by field with the oldest expectation.
  always @(posedge clk) begin
    spa_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (want.status != out_data.status ||
            want.slot != out_data.slot ||
            want.evicted_slot != out_data.evicted_slot ||
            want.removed_count != out_data.removed_count ||
            want.active_count != out_data.active_count) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    pool_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pool_full();
    test_config_phases();
    if (!failed)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
